>>> hdl/local_alignment_affine_score_defines.svh
// Assertion macros used by the checker of the local alignment scorer.
// Expects clk and rst_n to exist in the scope that uses them.
`ifndef LOCAL_ALIGNMENT_AFFINE_SCORE_DEFINES_SVH
`define LOCAL_ALIGNMENT_AFFINE_SCORE_DEFINES_SVH

// same-cycle implication
`define LASW_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LASW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/lasw_pkg.sv
// Shared constants, types and codes of the local alignment scorer.
// No dependencies.
package lasw_pkg;

  localparam int MAX_QUERY = 1024;
  localparam int ALPHABET  = 32;
  localparam int TAB_AW    = $clog2(ALPHABET);
  localparam int CODE_W    = 5;
  localparam int PAIR_W    = 8;
  localparam int ROW_W     = ALPHABET * PAIR_W;
  localparam int SCORE_W   = 20;
  localparam int GAP_W     = 22;
  localparam int CALC_W    = 23;
  localparam int PEN_W     = 8;
  localparam int OPEN_W    = PEN_W + 1;
  localparam int QLEN_W    = $clog2(MAX_QUERY + 1);
  localparam int INFL_W    = $clog2(MAX_QUERY + 2);
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};
  localparam logic signed [CALC_W-1:0] GAP_FLOOR = CALC_W'(-(2 ** (GAP_W - 1)));

  typedef enum logic [1:0] {
    OP_LOAD_TABLE   = 2'd0,
    OP_APPEND_QUERY = 2'd1,
    OP_CLEAR_QUERY  = 2'd2,
    OP_DB_RESIDUE   = 2'd3
  } op_t;

  localparam logic CFG_GAP_OPEN   = 1'b0;
  localparam logic CFG_GAP_EXTEND = 1'b1;

  // one database residue moving down the cell chain
  typedef struct packed {
    logic                       vld;
    logic                       first;
    logic                       last;
    logic [ROW_W-1:0]           row;
    logic [SCORE_W-1:0]         up_h;
    logic signed [GAP_W-1:0]    f;
    logic [SCORE_W-1:0]         diag;
    logic [SCORE_W-1:0]         mx;
    logic                       sat;
  } wave_t;

  typedef struct packed {
    logic              adv;
    logic [OPEN_W-1:0] open_cost;
    logic [PEN_W-1:0]  ext_cost;
  } cell_ctl_t;

endpackage

>>> hdl/lasw_sub_table.sv
// Substitution score table: one row per residue, one byte lane per column.
// Depends on lasw_pkg.
module lasw_sub_table import lasw_pkg::*; (
  input  logic                    clk,
  input  logic                    we,
  input  logic [TAB_AW-1:0]       wr_row,
  input  logic [TAB_AW-1:0]       wr_col,
  input  logic [PAIR_W-1:0]       wr_data,
  input  logic                    rd_en,
  input  logic [TAB_AW-1:0]       rd_row,
  output logic [ROW_W-1:0]        rd_data
);

  logic [ALPHABET-1:0][PAIR_W-1:0] mem [ALPHABET];
  logic [ROW_W-1:0]                rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_row][wr_col] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_row];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/lasw_cell.sv
// One query position of the scoring chain: holds its residue, H and E.
// Depends on lasw_pkg.
module lasw_cell import lasw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctl_t         ctl,
  input  logic              active,
  input  logic              q_we,
  input  logic [CODE_W-1:0] q_wdata,
  input  wave_t             wave_i,
  output wave_t             wave_o
);

  logic [CODE_W-1:0]        q_r;
  logic [SCORE_W-1:0]       h_r;
  logic signed [GAP_W-1:0]  e_r;
  wave_t                    wave_r, wave_nxt;

  logic [SCORE_W-1:0]       old_h;
  logic signed [GAP_W-1:0]  old_e;
  logic signed [PAIR_W-1:0] sc;
  logic signed [CALC_W-1:0] open_s, ext_s, e_a, e_b, e_m, e_c;
  logic signed [CALC_W-1:0] f_a, f_b, f_m, f_c, d, h_m;
  logic                     sat_now;
  logic [SCORE_W-1:0]       h_new;

  always_comb begin
    old_h  = wave_i.first ? '0 : h_r;
    old_e  = wave_i.first ? '0 : e_r;
    sc     = (32'(q_r) < ALPHABET) ? wave_i.row[q_r[TAB_AW-1:0]*PAIR_W +: PAIR_W] : '0;
    open_s = $signed({{(CALC_W-OPEN_W){1'b0}}, ctl.open_cost});
    ext_s  = $signed({{(CALC_W-PEN_W){1'b0}}, ctl.ext_cost});

    e_a = $signed({{(CALC_W-SCORE_W){1'b0}}, old_h}) - open_s;
    e_b = $signed({{(CALC_W-GAP_W){old_e[GAP_W-1]}}, old_e}) - ext_s;
    e_m = (e_a > e_b) ? e_a : e_b;
    e_c = (e_m < GAP_FLOOR) ? GAP_FLOOR : e_m;

    f_a = $signed({{(CALC_W-SCORE_W){1'b0}}, wave_i.up_h}) - open_s;
    f_b = $signed({{(CALC_W-GAP_W){wave_i.f[GAP_W-1]}}, wave_i.f}) - ext_s;
    f_m = (f_a > f_b) ? f_a : f_b;
    f_c = (f_m < GAP_FLOOR) ? GAP_FLOOR : f_m;

    d   = $signed({{(CALC_W-SCORE_W){1'b0}}, wave_i.diag})
        + $signed({{(CALC_W-PAIR_W){sc[PAIR_W-1]}}, sc});
    h_m = (d > $signed(CALC_W'(0))) ? d : '0;
    if (e_c > h_m) h_m = e_c;
    if (f_c > h_m) h_m = f_c;

    sat_now = (h_m >= $signed({{(CALC_W-SCORE_W){1'b0}}, SCORE_MAX}));
    h_new   = sat_now ? SCORE_MAX : h_m[SCORE_W-1:0];

    wave_nxt = wave_i;
    if (wave_i.vld && active) begin
      wave_nxt.up_h = h_new;
      wave_nxt.f    = f_c[GAP_W-1:0];
      wave_nxt.diag = old_h;
      wave_nxt.mx   = (h_new > wave_i.mx) ? h_new : wave_i.mx;
      wave_nxt.sat  = wave_i.sat | sat_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_r.vld <= 1'b0;
    end else if (ctl.adv) begin
      wave_r <= wave_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      q_r <= q_wdata;
    end
    if (ctl.adv && wave_i.vld && active) begin
      h_r <= h_new;
      e_r <= e_c[GAP_W-1:0];
    end
  end

  assign wave_o = wave_r;

endmodule

>>> hdl/local_alignment_affine_score.sv
// Local alignment score, affine gaps: a chain of MAX_QUERY cells, one per query residue.
// Database residues stream in one per cycle while the output is not stalled; a result leaves
// after its last residue is taken, through the injection register, one register per cell
// and the output register. Table loads and query edits wait until the chain has drained.
// Synchronous active-low reset clears control state; H and E clear per sequence on the fly.
// Depends on lasw_pkg, lasw_sub_table and lasw_cell.
module local_alignment_affine_score import lasw_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // op[1:0], residue[6:2], column[11:7], pair_score[19:12]
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // best_score[19:0]
  output logic                   out_tuser,  // saturated[0]
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [PEN_W-1:0]       cfg_wdata
);

  op_t                       op;
  logic [CODE_W-1:0]         residue, column;
  logic [PAIR_W-1:0]         pair_score;
  logic                      is_db, acc, adv;

  logic [PEN_W-1:0]          gap_open_r, gap_ext_r;
  logic [QLEN_W-1:0]         qlen_r;
  logic                      in_seq_r;
  logic [INFL_W-1:0]         inflight_r;
  logic                      inj_vld_r, inj_first_r, inj_last_r, inj_oor_r;
  logic [SCORE_W-1:0]        acc_mx_r;
  logic                      acc_sat_r;
  logic                      out_vld_r, out_sat_r;
  logic [SCORE_W-1:0]        out_best_r;

  logic [ROW_W-1:0]          rd_row_data;
  cell_ctl_t                 ctl;
  wave_t                     waves [MAX_QUERY+1];
  logic [MAX_QUERY-1:0]      act, q_we;
  wave_t                     tail;
  logic [SCORE_W-1:0]        mx_comb;
  logic                      sat_comb;

  assign op         = op_t'(in_tdata[1:0]);
  assign residue    = in_tdata[6:2];
  assign column     = in_tdata[11:7];
  assign pair_score = in_tdata[19:12];

  assign adv       = !out_vld_r || out_tready;
  assign is_db     = (op == OP_DB_RESIDUE);
  assign in_tready = adv && (is_db || inflight_r == '0);
  assign acc       = in_tvalid && in_tready;

  // stored transposed: a row read by database residue holds one lane per query code
  lasw_sub_table u_table (
    .clk     (clk),
    .we      (acc && op == OP_LOAD_TABLE && 32'(residue) < ALPHABET && 32'(column) < ALPHABET),
    .wr_row  (column[TAB_AW-1:0]),
    .wr_col  (residue[TAB_AW-1:0]),
    .wr_data (pair_score),
    .rd_en   (adv),
    .rd_row  (residue[TAB_AW-1:0]),
    .rd_data (rd_row_data)
  );

  assign ctl.adv       = adv;
  assign ctl.open_cost = {1'b0, gap_open_r} + {1'b0, gap_ext_r};
  assign ctl.ext_cost  = gap_ext_r;

  always_comb begin
    waves[0]       = '0;
    waves[0].vld   = inj_vld_r;
    waves[0].first = inj_first_r;
    waves[0].last  = inj_last_r;
    waves[0].row   = inj_oor_r ? '0 : rd_row_data;
  end

  for (genvar i = 0; i < MAX_QUERY; i++) begin : g_cell
    assign act[i]  = (QLEN_W'(i) < qlen_r);
    assign q_we[i] = acc && op == OP_APPEND_QUERY && !in_seq_r && qlen_r == QLEN_W'(i);
    lasw_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .active  (act[i]),
      .q_we    (q_we[i]),
      .q_wdata (residue),
      .wave_i  (waves[i]),
      .wave_o  (waves[i+1])
    );
  end

  assign tail = waves[MAX_QUERY];

  // fold this residue's column maximum into the sequence maximum
  always_comb begin
    mx_comb  = tail.mx;
    sat_comb = tail.sat;
    if (!tail.first) begin
      mx_comb  = (acc_mx_r > tail.mx) ? acc_mx_r : tail.mx;
      sat_comb = acc_sat_r | tail.sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_open_r <= PEN_W'(11);
      gap_ext_r  <= PEN_W'(1);
      qlen_r     <= '0;
      in_seq_r   <= 1'b0;
      inflight_r <= '0;
      inj_vld_r  <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_GAP_OPEN:   gap_open_r <= cfg_wdata;
          CFG_GAP_EXTEND: gap_ext_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (acc && !in_seq_r) begin
        if (op == OP_APPEND_QUERY && 32'(qlen_r) < MAX_QUERY) begin
          qlen_r <= qlen_r + QLEN_W'(1);
        end else if (op == OP_CLEAR_QUERY) begin
          qlen_r <= '0;
        end
      end
      if (acc && is_db) begin
        in_seq_r <= !in_tlast;
      end
      inflight_r <= inflight_r + INFL_W'(acc && is_db) - INFL_W'(adv && tail.vld);
      if (adv) begin
        inj_vld_r <= acc && is_db;
        out_vld_r <= tail.vld && tail.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      inj_first_r <= !in_seq_r;
      inj_last_r  <= in_tlast;
      inj_oor_r   <= !(32'(residue) < ALPHABET);
      if (tail.vld) begin
        acc_mx_r   <= mx_comb;
        acc_sat_r  <= sat_comb;
        out_best_r <= mx_comb;
        out_sat_r  <= sat_comb;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_TDATA_W-SCORE_W){1'b0}}, out_best_r};
  assign out_tuser  = out_sat_r;

endmodule

>>> hdl/lasw_checker.sv
// Port-level checks of the local alignment scorer, bound to the top level.
// Depends on lasw_pkg and local_alignment_affine_score_defines.svh.
`include "local_alignment_affine_score_defines.svh"

module lasw_checker import lasw_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser
);

  // a pending result holds its value until taken
  `LASW_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "hold")
  // a stalled result stalls the input side too
  `LASW_ASSERT_SAME(a_in_stall, out_tvalid && !out_tready, !in_tready, "input taken in stall")
  // saturation flag implies the score sits at its ceiling
  `LASW_ASSERT_SAME(a_sat_max, out_tvalid && out_tuser, out_tdata[SCORE_W-1:0] == SCORE_MAX, "sat")
  // no result right after reset
  `LASW_ASSERT_SAME(a_rst_idle, $rose(rst_n), !out_tvalid, "result valid out of reset")

endmodule

bind local_alignment_affine_score lasw_checker u_lasw_checker (.*);
